// ===== hdl/drcd_pkg.sv =====
// Package for the depth rod column detector.
// Holds the configuration register indexes, their reset values and the
// configuration record. No dependencies.
package drcd_pkg;

    // Widths of the configuration registers.
    localparam int LEVEL_BITS = 8;
    localparam int BOUND_BITS = 10;
    localparam int LIMIT_BITS = 11;
    localparam int GAP_BITS   = 4;
    localparam int RUN_BITS   = 10;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 4;

    // Saturation value of the run counter.
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LEVEL_THRESHOLD = 4'd0,
        CFG_ROW_FIRST       = 4'd1,
        CFG_ROW_LIMIT       = 4'd2,
        CFG_COL_FIRST       = 4'd3,
        CFG_COL_LIMIT       = 4'd4,
        CFG_MIN_RUN         = 4'd5,
        CFG_MAX_WIDTH       = 4'd6,
        CFG_GAP_TOLERANCE   = 4'd7
    } cfg_idx_t;

    // Configuration record shared by the top level and the core.
    typedef struct packed {
        logic [LEVEL_BITS-1:0] level_threshold;
        logic [BOUND_BITS-1:0] row_first;
        logic [LIMIT_BITS-1:0] row_limit;
        logic [BOUND_BITS-1:0] col_first;
        logic [LIMIT_BITS-1:0] col_limit;
        logic [RUN_BITS-1:0]   min_run;
        logic [BOUND_BITS-1:0] max_width;
        logic [GAP_BITS-1:0]   gap_tolerance;
    } cfg_t;

    // Reset values of the configuration registers.
    localparam cfg_t CFG_RESET = '{
        level_threshold: 8'd96,
        row_first:       10'd240,
        row_limit:       11'd320,
        col_first:       10'd61,
        col_limit:       11'd420,
        min_run:         10'd35,
        max_width:       10'd7,
        gap_tolerance:   4'd2
    };

endpackage

// ===== hdl/drcd_core.sv =====
// Per-pixel run tracking, column grouping and frame-end judgement.
// Holds all frame state; updated once per stepped item.
// Depends on drcd_pkg.
module drcd_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drcd_pkg::cfg_t        cfg,
    input  logic                  step,
    input  logic [7:0]            pixel_level,
    input  logic [COORD_BITS-1:0] pixel_row,
    input  logic [COORD_BITS-1:0] pixel_col,
    input  logic                  frame_end,
    output logic                  found,
    output logic [COORD_BITS-1:0] rod_column
);
    import drcd_pkg::*;

    localparam int CW = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
    localparam int GW = COORD_BITS + 1;
    localparam int MW = (GW > BOUND_BITS) ? GW : BOUND_BITS;

    typedef struct packed {
        logic                  found;
        logic [COORD_BITS-1:0] col;
    } hit_t;

    // Judge a closed group: the first group of width 2..max_width wins.
    function automatic hit_t judge(
        input logic                  open,
        input logic [COORD_BITS-1:0] start,
        input logic [COORD_BITS-1:0] last,
        input hit_t                  prev,
        input logic [BOUND_BITS-1:0] maxw
    );
        hit_t           r;
        logic [GW-1:0]  w;
        logic [GW-1:0]  mid;
        r   = prev;
        w   = GW'(last) - GW'(start) + GW'(1);
        mid = GW'(start) + (w >> 1);
        if (open && !prev.found && (w >= GW'(2)) && (MW'(w) <= MW'(maxw)))
        begin
            r.found = 1'b1;
            r.col   = mid[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic [COORD_BITS-1:0] run_column_reg,   run_column_next;
    logic                  column_open_reg,  column_open_next;
    logic [COORD_BITS-1:0] last_run_row_reg, last_run_row_next;
    logic [RUN_BITS-1:0]   run_count_reg,    run_count_next;
    logic                  column_flagged_reg, column_flagged_next;
    logic                  group_open_reg,   group_open_next;
    logic [COORD_BITS-1:0] group_start_reg,  group_start_next;
    logic [COORD_BITS-1:0] group_last_reg,   group_last_next;
    hit_t                  hit_reg,          hit_next;

    logic                  white;
    logic                  new_run;
    logic                  gap_ok;
    logic [RUN_BITS-1:0]   cnt_after;
    logic                  flag_evt;
    logic                  extend;
    hit_t                  hit_mid;
    hit_t                  hit_final;
    logic                  grp_open_post;
    logic [COORD_BITS-1:0] grp_start_post;
    logic [COORD_BITS-1:0] grp_last_post;

    // Pixel classification against the window and the level threshold.
    always_comb
    begin
        white = (CW'(pixel_row) >= CW'(cfg.row_first)) &&
                (CW'(pixel_row) <  CW'(cfg.row_limit)) &&
                (CW'(pixel_col) >= CW'(cfg.col_first)) &&
                (CW'(pixel_col) <  CW'(cfg.col_limit)) &&
                (pixel_level > cfg.level_threshold);
        new_run = !column_open_reg || (pixel_col != run_column_reg);
        gap_ok  = GW'(pixel_row) <= (GW'(last_run_row_reg) + GW'(cfg.gap_tolerance));
    end

    // Run counting and column flagging.
    always_comb
    begin
        cnt_after = run_count_reg;
        if (gap_ok && (run_count_reg < RUN_MAX))
        begin
            cnt_after = run_count_reg + RUN_BITS'(1);
        end
        flag_evt = white && !new_run && (cnt_after >= cfg.min_run) && !column_flagged_reg;
        extend   = group_open_reg && (GW'(pixel_col) == (GW'(group_last_reg) + GW'(1)));
    end

    // Group bookkeeping and the frame-end judgement.
    always_comb
    begin
        hit_mid        = hit_reg;
        grp_open_post  = group_open_reg;
        grp_start_post = group_start_reg;
        grp_last_post  = group_last_reg;
        if (flag_evt)
        begin
            if (extend)
            begin
                grp_last_post = pixel_col;
            end
            else
            begin
                hit_mid = judge(group_open_reg, group_start_reg, group_last_reg,
                                hit_reg, cfg.max_width);
                grp_open_post  = 1'b1;
                grp_start_post = pixel_col;
                grp_last_post  = pixel_col;
            end
        end
        hit_final = judge(grp_open_post, grp_start_post, grp_last_post, hit_mid,
                          cfg.max_width);
        found      = hit_final.found;
        rod_column = hit_final.found ? hit_final.col : '0;
    end

    // Next state of the frame registers.
    always_comb
    begin
        run_column_next     = run_column_reg;
        column_open_next    = column_open_reg;
        last_run_row_next   = last_run_row_reg;
        run_count_next      = run_count_reg;
        column_flagged_next = column_flagged_reg;
        group_open_next     = group_open_reg;
        group_start_next    = group_start_reg;
        group_last_next     = group_last_reg;
        hit_next            = hit_reg;
        if (step)
        begin
            if (frame_end)
            begin
                run_column_next     = '0;
                column_open_next    = 1'b0;
                last_run_row_next   = '0;
                run_count_next      = '0;
                column_flagged_next = 1'b0;
                group_open_next     = 1'b0;
                group_start_next    = '0;
                group_last_next     = '0;
                hit_next            = '0;
            end
            else
            begin
                if (white)
                begin
                    if (new_run)
                    begin
                        run_column_next     = pixel_col;
                        column_open_next    = 1'b1;
                        last_run_row_next   = pixel_row;
                        run_count_next      = '0;
                        column_flagged_next = 1'b0;
                    end
                    else
                    begin
                        if (gap_ok)
                        begin
                            last_run_row_next = pixel_row;
                        end
                        run_count_next = cnt_after;
                        if (flag_evt)
                        begin
                            column_flagged_next = 1'b1;
                        end
                    end
                end
                group_open_next  = grp_open_post;
                group_start_next = grp_start_post;
                group_last_next  = grp_last_post;
                hit_next         = hit_mid;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_column_reg     <= '0;
            column_open_reg    <= 1'b0;
            last_run_row_reg   <= '0;
            run_count_reg      <= '0;
            column_flagged_reg <= 1'b0;
            group_open_reg     <= 1'b0;
            group_start_reg    <= '0;
            group_last_reg     <= '0;
            hit_reg            <= '0;
        end
        else
        begin
            run_column_reg     <= run_column_next;
            column_open_reg    <= column_open_next;
            last_run_row_reg   <= last_run_row_next;
            run_count_reg      <= run_count_next;
            column_flagged_reg <= column_flagged_next;
            group_open_reg     <= group_open_next;
            group_start_reg    <= group_start_next;
            group_last_reg     <= group_last_next;
            hit_reg            <= hit_next;
        end
    end

endmodule

// ===== hdl/depth_rod_column_detector_top.sv =====
// Depth rod column detector: input register, detection core, result register.
// An item is accepted into the input register; a frame-end item is judged as it is
// processed and loads its result into the result register. Throughput:
// one item per cycle; only a frame-end item waits, while the result register is
// full and stalled.
// Reset: configuration registers return to their defaults, frame state clears.
// Depends on drcd_pkg and drcd_core.
module depth_rod_column_detector_top #(
    parameter int COORD_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [drcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [drcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [7:0]                          pixel_level,
    input  logic [COORD_BITS-1:0]               pixel_row,
    input  logic [COORD_BITS-1:0]               pixel_col,
    input  logic                                frame_end,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                found,
    output logic [COORD_BITS-1:0]               rod_column
);
    import drcd_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  pix_vld_reg, pix_vld_next;
    logic [7:0]            pix_level_reg;
    logic [COORD_BITS-1:0] pix_row_reg;
    logic [COORD_BITS-1:0] pix_col_reg;
    logic                  pix_fe_reg;
    logic                  res_vld_reg, res_vld_next;
    logic                  res_found_reg;
    logic [COORD_BITS-1:0] res_col_reg;
    logic                  fire;
    logic                  fire_fe;
    logic                  core_found;
    logic [COORD_BITS-1:0] core_col;

    // Configuration register write decoder.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LEVEL_THRESHOLD: cfg_next.level_threshold = cfg_data[LEVEL_BITS-1:0];
                CFG_ROW_FIRST:       cfg_next.row_first       = cfg_data[BOUND_BITS-1:0];
                CFG_ROW_LIMIT:       cfg_next.row_limit       = cfg_data[LIMIT_BITS-1:0];
                CFG_COL_FIRST:       cfg_next.col_first       = cfg_data[BOUND_BITS-1:0];
                CFG_COL_LIMIT:       cfg_next.col_limit       = cfg_data[LIMIT_BITS-1:0];
                CFG_MIN_RUN:         cfg_next.min_run         = cfg_data[RUN_BITS-1:0];
                CFG_MAX_WIDTH:       cfg_next.max_width       = cfg_data[BOUND_BITS-1:0];
                CFG_GAP_TOLERANCE:   cfg_next.gap_tolerance   = cfg_data[GAP_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Handshake: the held item is processed unless it ends a frame and the
    // result register cannot take its result this cycle.
    always_comb
    begin
        fire         = pix_vld_reg && (!pix_fe_reg || !res_vld_reg || !result_stall);
        fire_fe      = fire && pix_fe_reg;
        pixel_stall  = pix_vld_reg && !fire;
        pix_vld_next = pixel_stall ? pix_vld_reg : pixel_valid;
        res_vld_next = fire_fe ? 1'b1 : (result_stall ? res_vld_reg : 1'b0);
    end

    drcd_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .step        (fire),
        .pixel_level (pix_level_reg),
        .pixel_row   (pix_row_reg),
        .pixel_col   (pix_col_reg),
        .frame_end   (pix_fe_reg),
        .found       (core_found),
        .rod_column  (core_col)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= CFG_RESET;
            pix_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            pix_vld_reg <= pix_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Input item register.
    always_ff @(posedge clk)
    begin
        if (pixel_valid && !pixel_stall)
        begin
            pix_level_reg <= pixel_level;
            pix_row_reg   <= pixel_row;
            pix_col_reg   <= pixel_col;
            pix_fe_reg    <= frame_end;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (fire_fe)
        begin
            res_found_reg <= core_found;
            res_col_reg   <= core_col;
        end
    end

    assign result_valid = res_vld_reg;
    assign found        = res_found_reg;
    assign rod_column   = res_col_reg;

    // A result that reports no rod carries column zero.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (rod_column == '0))
        else $error("rod_column not zero on a not-found result");

    // The input side stalls only behind a frame-end item blocked at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (pix_vld_reg && pix_fe_reg && res_vld_reg && result_stall))
        else $error("input stalled without a blocked frame-end item");

    // A new result appears only after a frame-end item was processed.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(fire_fe))
        else $error("result raised without a frame-end item");

    // A frame-end item is never processed over a waiting, stalled result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire_fe |-> !(res_vld_reg && result_stall))
        else $error("result register overwritten while stalled");

endmodule
